### src/dzq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dzq_pkg
// Shared types and constants for the dead-zone coefficient dequantizer.
// ----------------------------------------------------------------------------
package dzq_pkg;

  localparam int CoefW    = 16;
  localparam int StepW    = 15;
  localparam int OffW     = 16;
  localparam int OffEffW  = OffW + 1;
  localparam int ProdW    = 31;
  localparam int SumW     = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [StepW-1:0]       StepReset = StepW'(1);
  localparam logic signed [OffW-1:0] OffReset  = '0;

  localparam logic signed [SumW-1:0]  SatHiWide = 32'sd32767;
  localparam logic signed [SumW-1:0]  SatLoWide = -32'sd32768;
  localparam logic signed [CoefW-1:0] SatHi     = 16'sh7fff;
  localparam logic signed [CoefW-1:0] SatLo     = 16'sh8000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEP_TEMPORAL   = 2'd0,
    CFG_OFFSET_TEMPORAL = 2'd1,
    CFG_STEP_INTRA      = 2'd2,
    CFG_OFFSET_INTRA    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [StepW-1:0]       step_temporal;
    logic signed [OffW-1:0] offset_temporal;
    logic [StepW-1:0]       step_intra;
    logic signed [OffW-1:0] offset_intra;
  } dzq_cfg_t;

  typedef struct packed {
    logic signed [ProdW-1:0]   prod;
    logic signed [OffEffW-1:0] off_eff;
  } dzq_prod_t;

endpackage
`default_nettype wire

### src/dzq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dzq_in_if / dzq_out_if
// Valid/ready channels for coefficient beats and dequantized beats.
// ----------------------------------------------------------------------------
interface dzq_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [dzq_pkg::CoefW-1:0]    coefficient;
  logic                                temporal_flag;

  modport source (output valid, output coefficient, output temporal_flag, input ready);
  modport sink   (input valid, input coefficient, input temporal_flag, output ready);
endinterface

interface dzq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dzq_pkg::CoefW-1:0]    dequantized;

  modport source (output valid, output dequantized, input ready);
  modport sink   (input valid, input dequantized, output ready);
endinterface
`default_nettype wire

### src/dzq_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dzq_cfg_regs
// Step-width and offset register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dzq_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [dzq_pkg::CfgIdxW-1:0]   cfg_idx,
  input  wire logic [dzq_pkg::CfgDataW-1:0]  cfg_data,
  output dzq_pkg::dzq_cfg_t                  cfg
);

  dzq_pkg::dzq_cfg_t cfg_r;
  dzq_pkg::dzq_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (dzq_pkg::cfg_idx_t'(cfg_idx))
        dzq_pkg::CFG_STEP_TEMPORAL:   cfg_nxt.step_temporal   = cfg_data[dzq_pkg::StepW-1:0];
        dzq_pkg::CFG_OFFSET_TEMPORAL: cfg_nxt.offset_temporal = $signed(cfg_data);
        dzq_pkg::CFG_STEP_INTRA:      cfg_nxt.step_intra      = cfg_data[dzq_pkg::StepW-1:0];
        dzq_pkg::CFG_OFFSET_INTRA:    cfg_nxt.offset_intra    = $signed(cfg_data);
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_temporal   <= dzq_pkg::StepReset;
      cfg_r.offset_temporal <= dzq_pkg::OffReset;
      cfg_r.step_intra      <= dzq_pkg::StepReset;
      cfg_r.offset_intra    <= dzq_pkg::OffReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### src/dzq_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dzq_mul
// Stage 1 selects the register pair and signs the offset; stage 2 forms the
// coefficient times step-width product.
// ----------------------------------------------------------------------------
module dzq_mul (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire dzq_pkg::dzq_cfg_t cfg,
  dzq_in_if.sink             in_if,
  output logic               prod_valid,
  input  wire logic          prod_ready,
  output dzq_pkg::dzq_prod_t prod_data
);

  logic                                  s1_valid_r;
  logic signed [dzq_pkg::CoefW-1:0]      s1_coef_r;
  logic [dzq_pkg::StepW-1:0]             s1_step_r;
  logic signed [dzq_pkg::OffEffW-1:0]    s1_off_r;
  logic signed [dzq_pkg::OffEffW-1:0]    s1_off_nxt;
  logic signed [dzq_pkg::OffW-1:0]       off_sel;
  logic signed [dzq_pkg::OffEffW-1:0]    off_wide;
  logic                                  s1_ready;

  logic                                  s2_valid_r;
  dzq_pkg::dzq_prod_t                    s2_data_r;
  dzq_pkg::dzq_prod_t                    s2_data_nxt;
  logic signed [dzq_pkg::SumW-1:0]       prod_full;
  logic                                  s2_ready;

  assign s2_ready    = !s2_valid_r || prod_ready;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_if.ready = s1_ready;

  // sign the offset by the coefficient's sign; zero coefficient gets none
  always_comb begin
    off_sel  = in_if.temporal_flag ? cfg.offset_temporal : cfg.offset_intra;
    off_wide = {off_sel[dzq_pkg::OffW-1], off_sel};
    if (in_if.coefficient == '0) begin
      s1_off_nxt = '0;
    end else if (in_if.coefficient[dzq_pkg::CoefW-1]) begin
      s1_off_nxt = -off_wide;
    end else begin
      s1_off_nxt = off_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_if.valid) begin
      s1_coef_r <= in_if.coefficient;
      s1_step_r <= in_if.temporal_flag ? cfg.step_temporal : cfg.step_intra;
      s1_off_r  <= s1_off_nxt;
    end
  end

  always_comb begin
    prod_full           = dzq_pkg::SumW'(s1_coef_r) *
                          dzq_pkg::SumW'($signed({1'b0, s1_step_r}));
    s2_data_nxt.prod    = prod_full[dzq_pkg::ProdW-1:0];
    s2_data_nxt.off_eff = s1_off_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign prod_valid = s2_valid_r;
  assign prod_data  = s2_data_r;

endmodule
`default_nettype wire

### src/dzq_sum_sat.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dzq_sum_sat
// Stage 3 adds the signed offset to the product; stage 4 clamps the sum to
// signed 16 bits and holds the result beat.
// ----------------------------------------------------------------------------
module dzq_sum_sat (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          prod_valid,
  output logic               prod_ready,
  input  wire dzq_pkg::dzq_prod_t prod_data,
  dzq_out_if.source          out_if
);

  logic                               s3_valid_r;
  logic signed [dzq_pkg::SumW-1:0]    s3_sum_r;
  logic signed [dzq_pkg::SumW-1:0]    s3_sum_nxt;
  logic                               s3_ready;

  logic                               s4_valid_r;
  logic signed [dzq_pkg::CoefW-1:0]   s4_res_r;
  logic signed [dzq_pkg::CoefW-1:0]   s4_res_nxt;
  logic                               s4_ready;

  assign s4_ready   = !s4_valid_r || out_if.ready;
  assign s3_ready   = !s3_valid_r || s4_ready;
  assign prod_ready = s3_ready;

  assign s3_sum_nxt =
    {{(dzq_pkg::SumW-dzq_pkg::ProdW){prod_data.prod[dzq_pkg::ProdW-1]}}, prod_data.prod} +
    {{(dzq_pkg::SumW-dzq_pkg::OffEffW){prod_data.off_eff[dzq_pkg::OffEffW-1]}},
     prod_data.off_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && prod_valid) begin
      s3_sum_r <= s3_sum_nxt;
    end
  end

  always_comb begin
    if (s3_sum_r > dzq_pkg::SatHiWide) begin
      s4_res_nxt = dzq_pkg::SatHi;
    end else if (s3_sum_r < dzq_pkg::SatLoWide) begin
      s4_res_nxt = dzq_pkg::SatLo;
    end else begin
      s4_res_nxt = s3_sum_r[dzq_pkg::CoefW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (s4_ready) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid_r) begin
      s4_res_r <= s4_res_nxt;
    end
  end

  assign out_if.valid       = s4_valid_r;
  assign out_if.dequantized = s4_res_r;

endmodule
`default_nettype wire

### src/deadzone_coefficient_dequantizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadzone_coefficient_dequantizer_core
// Dead-zone inverse quantizer for signed 16-bit residual coefficients.
//
// in_if carries one coefficient and its temporal-prediction flag per beat;
// out_if returns the dequantized coefficient, saturated to signed 16 bits,
// one beat per input beat and in the same order. The flag picks the temporal
// or the intra step-width/offset pair from the cfg_ write port (index 0 step
// temporal, 1 offset temporal, 2 step intra, 3 offset intra).
// Each beat passes the registered stages pair select, multiply, offset add and
// saturate, in that order. One beat is accepted every cycle while the receiver
// takes results; every stage takes a new beat each cycle.
// When the receiver stalls, each stage holds its beat and in_if.ready drops
// only once the pipeline is full. Reset empties the pipeline and loads step
// widths of 1 and offsets of 0. Write the registers only while idle.
// ----------------------------------------------------------------------------
module deadzone_coefficient_dequantizer_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [dzq_pkg::CfgIdxW-1:0]   cfg_idx,
  input  wire logic [dzq_pkg::CfgDataW-1:0]  cfg_data,
  dzq_in_if.sink                             in_if,
  dzq_out_if.source                          out_if
);

  dzq_pkg::dzq_cfg_t  cfg;
  logic               prod_valid;
  logic               prod_ready;
  dzq_pkg::dzq_prod_t prod_data;

  dzq_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  dzq_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_if      (in_if),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod_data  (prod_data)
  );

  dzq_sum_sat u_sum_sat (
    .clk        (clk),
    .rst_n      (rst_n),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod_data  (prod_data),
    .out_if     (out_if)
  );

endmodule
`default_nettype wire
